// ===== src/cbf_pkg.sv =====
// Package for the cassette block framer: request/result payload types, phase
// encoding, framer state, configuration register set and tape format constants.
// No dependencies.
`default_nettype none

package cbf_pkg;

  // Default sizes of the tape format
  localparam int unsigned LEADER_LENGTH_DEF = 128;
  localparam int unsigned BLOCK_MAX_DEF     = 255;
  localparam int unsigned NAME_CHARS        = 8;

  // Name block payload: name, file type, two mode bytes, exec and load addresses
  localparam logic [7:0] NAME_LEN = 8'(NAME_CHARS + 7);

  // Tape format bytes
  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [7:0] MAGIC_BYTE     = 8'h3C;
  localparam logic [7:0] TYPE_NAME      = 8'h00;
  localparam logic [7:0] TYPE_DATA      = 8'h01;
  localparam logic [7:0] TYPE_EOF       = 8'hFF;
  localparam logic [7:0] FILE_TYPE_ML   = 8'h02;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [7:0] EOF_FRAME_LEN  = 8'd6;
  localparam logic [7:0] LOWER_A        = 8'h61;
  localparam logic [7:0] LOWER_Z        = 8'h7A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXEC_ADDRESS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_TEXT    = 2'd3;

  localparam logic [63:0] NAME_TEXT_RESET = 64'h2020_2020_2020_2020;

  typedef enum logic [3:0] {
    PH_LEAD1  = 4'd0,
    PH_NAME   = 4'd1,
    PH_LEAD2  = 4'd2,
    PH_DSYNC  = 4'd3,
    PH_DMAGIC = 4'd4,
    PH_DTYPE  = 4'd5,
    PH_DLEN   = 4'd6,
    PH_DPAY   = 4'd7,
    PH_DSUM   = 4'd8,
    PH_DTRAIL = 4'd9,
    PH_EOF    = 4'd10,
    PH_DONE   = 4'd11
  } cbf_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
  } cbf_request_t;

  typedef struct packed {
    logic [7:0] tape_byte;
    logic       tape_valid;
    logic       data_taken;
    logic       stream_done;
  } cbf_result_t;

  typedef struct packed {
    cbf_phase_t  phase;
    logic [7:0]  position;
    logic [15:0] bytes_left;
    logic [7:0]  block_length;
    logic [7:0]  running_sum;
    logic        finished;
  } cbf_state_t;

  typedef struct packed {
    logic [15:0] total_length;
    logic [15:0] load_address;
    logic [15:0] exec_address;
    logic [63:0] name_text;
  } cbf_cfg_t;

endpackage

`default_nettype wire

// ===== src/cbf_cfg.sv =====
// Configuration register file of the cassette block framer.
// Depends on cbf_pkg for the register indexes and the register set type.
`default_nettype none

module cbf_cfg
  import cbf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cbf_cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_length <= '0;
      cfg.load_address <= '0;
      cfg.exec_address <= '0;
      cfg.name_text    <= NAME_TEXT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOTAL_LENGTH: cfg.total_length <= cfg_data[15:0];
        REG_LOAD_ADDRESS: cfg.load_address <= cfg_data[15:0];
        REG_EXEC_ADDRESS: cfg.exec_address <= cfg_data[15:0];
        REG_NAME_TEXT:    cfg.name_text    <= cfg_data;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cbf_step.sv =====
// Single-step framing logic: next framer state and the tape byte for one request.
// Purely combinational; depends on cbf_pkg.
`default_nettype none

module cbf_step
  import cbf_pkg::*;
#(
  parameter int unsigned LEADER_LENGTH = LEADER_LENGTH_DEF,
  parameter int unsigned BLOCK_MAX     = BLOCK_MAX_DEF
) (
  input  wire cbf_state_t   cur,
  input  wire cbf_cfg_t     cfg,
  input  wire cbf_request_t req,
  output cbf_state_t        nxt,
  output cbf_result_t       res
);

  logic [8:0]  pos_inc;
  logic [7:0]  name_idx;
  logic [2:0]  char_sel;
  logic [7:0]  name_char;
  logic [7:0]  name_byte;
  logic [15:0] exec_eff;
  logic [7:0]  blk_len;
  logic [7:0]  eof_byte;

  assign pos_inc  = {1'b0, cur.position} + 9'd1;
  assign name_idx = cur.position - 8'd4;
  assign char_sel = 3'd7 - name_idx[2:0];
  assign name_char = cfg.name_text[{char_sel, 3'b000} +: 8];
  assign exec_eff = (cfg.exec_address != 16'd0) ? cfg.exec_address : cfg.load_address;
  assign blk_len  = (cur.bytes_left < 16'(BLOCK_MAX)) ? cur.bytes_left[7:0] : 8'(BLOCK_MAX);

  // Name block payload byte at the current position
  always_comb begin
    unique case (name_idx)
      8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7: begin
        if (name_char >= LOWER_A && name_char <= LOWER_Z) begin
          name_byte = name_char - CASE_OFFSET;
        end else begin
          name_byte = name_char;
        end
      end
      8'd8:    name_byte = FILE_TYPE_ML;
      8'd9:    name_byte = ZERO_BYTE;
      8'd10:   name_byte = ZERO_BYTE;
      8'd11:   name_byte = exec_eff[15:8];
      8'd12:   name_byte = exec_eff[7:0];
      8'd13:   name_byte = cfg.load_address[15:8];
      default: name_byte = cfg.load_address[7:0];
    endcase
  end

  always_comb begin
    unique case (cur.position)
      8'd0:    eof_byte = SYNC_BYTE;
      8'd1:    eof_byte = MAGIC_BYTE;
      8'd2:    eof_byte = TYPE_EOF;
      8'd3:    eof_byte = ZERO_BYTE;
      8'd4:    eof_byte = TYPE_EOF;
      default: eof_byte = SYNC_BYTE;
    endcase
  end

  // Next state
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_LEAD1, PH_LEAD2: begin
        if (cur.phase == PH_LEAD1 && cur.position == 8'd0) begin
          nxt.bytes_left = cfg.total_length;
        end
        nxt.position = pos_inc[7:0];
        if (pos_inc >= 9'(LEADER_LENGTH)) begin
          nxt.position = '0;
          if (cur.phase == PH_LEAD1) begin
            nxt.phase = PH_NAME;
          end else if (cur.bytes_left != 16'd0) begin
            nxt.block_length = blk_len;
            nxt.phase        = PH_DSYNC;
          end else begin
            nxt.phase = PH_EOF;
          end
        end
      end
      PH_NAME: begin
        if (cur.position == 8'd2) begin
          nxt.running_sum = '0;
        end else if (cur.position == 8'd3) begin
          nxt.running_sum = cur.running_sum + NAME_LEN;
        end else if (cur.position >= 8'd4 && cur.position < NAME_LEN + 8'd4) begin
          nxt.running_sum = cur.running_sum + name_byte;
        end
        nxt.position = pos_inc[7:0];
        if (cur.position >= NAME_LEN + 8'd5) begin
          nxt.phase    = PH_LEAD2;
          nxt.position = '0;
        end
      end
      PH_DSYNC:  nxt.phase = PH_DMAGIC;
      PH_DMAGIC: nxt.phase = PH_DTYPE;
      PH_DTYPE: begin
        nxt.running_sum = TYPE_DATA;
        nxt.phase       = PH_DLEN;
      end
      PH_DLEN: begin
        nxt.running_sum = cur.running_sum + cur.block_length;
        nxt.position    = '0;
        nxt.phase       = PH_DPAY;
      end
      PH_DPAY: begin
        if (req.data_valid) begin
          nxt.running_sum = cur.running_sum + req.data_byte;
          nxt.bytes_left  = cur.bytes_left - 16'd1;
          nxt.position    = pos_inc[7:0];
          if (pos_inc >= {1'b0, cur.block_length}) begin
            nxt.phase = PH_DSUM;
          end
        end
      end
      PH_DSUM: nxt.phase = PH_DTRAIL;
      PH_DTRAIL: begin
        nxt.position = '0;
        if (cur.bytes_left != 16'd0) begin
          nxt.block_length = blk_len;
          nxt.phase        = PH_DSYNC;
        end else begin
          nxt.phase = PH_EOF;
        end
      end
      PH_EOF: begin
        nxt.position = pos_inc[7:0];
        if (pos_inc >= {1'b0, EOF_FRAME_LEN}) begin
          nxt.phase    = PH_DONE;
          nxt.position = '0;
          nxt.finished = 1'b1;
        end
      end
      default: nxt.phase = PH_DONE;
    endcase
  end

  // Tape byte for this step
  always_comb begin
    res.tape_byte   = ZERO_BYTE;
    res.tape_valid  = 1'b1;
    res.data_taken  = 1'b0;
    res.stream_done = nxt.finished;
    unique case (cur.phase)
      PH_LEAD1, PH_LEAD2: res.tape_byte = SYNC_BYTE;
      PH_NAME: begin
        if (cur.position == 8'd0) begin
          res.tape_byte = SYNC_BYTE;
        end else if (cur.position == 8'd1) begin
          res.tape_byte = MAGIC_BYTE;
        end else if (cur.position == 8'd2) begin
          res.tape_byte = TYPE_NAME;
        end else if (cur.position == 8'd3) begin
          res.tape_byte = NAME_LEN;
        end else if (cur.position < NAME_LEN + 8'd4) begin
          res.tape_byte = name_byte;
        end else if (cur.position == NAME_LEN + 8'd4) begin
          res.tape_byte = cur.running_sum;
        end else begin
          res.tape_byte = SYNC_BYTE;
        end
      end
      PH_DSYNC:  res.tape_byte = SYNC_BYTE;
      PH_DMAGIC: res.tape_byte = MAGIC_BYTE;
      PH_DTYPE:  res.tape_byte = TYPE_DATA;
      PH_DLEN:   res.tape_byte = cur.block_length;
      PH_DPAY: begin
        if (req.data_valid) begin
          res.tape_byte  = req.data_byte;
          res.data_taken = 1'b1;
        end else begin
          res.tape_valid = 1'b0;
        end
      end
      PH_DSUM:   res.tape_byte = cur.running_sum;
      PH_DTRAIL: res.tape_byte = SYNC_BYTE;
      PH_EOF:    res.tape_byte = eof_byte;
      default:   res.tape_valid = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/cassette_block_framer.sv =====
// Top level of the cassette block framer: request register, framer state,
// result register. Depends on cbf_pkg, cbf_cfg and cbf_step.
//
// Usage:
//  - Request channel (request_valid / request_stall / request): one request per
//    tape step, carrying an optional payload byte (data_valid marks it offered).
//  - Result channel (result_valid / result_stall / result): exactly one result
//    per request: the tape byte (or none), whether the payload byte was taken,
//    and whether the end block has been sent.
//  - Configuration: write total_length, addresses and name with cfg_write while
//    idle; a leader starts on the first request after reset.
//  - Flow: an accepted request is stored in the request register, then the
//    framing step runs on it and the result register stores its result.
//  - Throughput: one request per cycle unless the result stalls. The framing
//    step is one pass of short logic over a small phase/position counter pair.
//  - Reset (rst, synchronous): both registers empty, framer back at the first
//    leader, configuration registers to their reset values.
//  - When the receiver stalls: the result holds; one more request is absorbed
//    in the request register, then request_stall rises until the result drains.
`default_nettype none

module cassette_block_framer
  import cbf_pkg::*;
#(
  parameter int unsigned LEADER_LENGTH = LEADER_LENGTH_DEF,
  parameter int unsigned BLOCK_MAX     = BLOCK_MAX_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   request_valid,
  output logic                        request_stall,
  input  wire cbf_request_t           request,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output cbf_result_t                 result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cbf_cfg_t     cfg;
  logic         held_valid;
  cbf_request_t held;
  cbf_state_t   state;
  cbf_state_t   state_next;
  cbf_result_t  step_result;
  logic         advance;
  logic         request_accept;

  cbf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbf_step #(
    .LEADER_LENGTH (LEADER_LENGTH),
    .BLOCK_MAX     (BLOCK_MAX)
  ) u_step (
    .cur (state),
    .cfg (cfg),
    .req (held),
    .nxt (state_next),
    .res (step_result)
  );

  // Result register frees up when empty or being taken this cycle
  assign advance        = !result_valid || !result_stall;
  assign request_stall  = held_valid && !advance;
  assign request_accept = request_valid && !request_stall;

  // Request register: hold while the result side is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (request_accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request_accept) begin
      held <= request;
    end
  end

  // Framer state advances exactly once per request, when its result is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_LEAD1;
      state.position     <= '0;
      state.bytes_left   <= '0;
      state.block_length <= '0;
      state.running_sum  <= '0;
      state.finished     <= 1'b0;
    end else if (advance && held_valid) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      result <= step_result;
    end
  end

endmodule

`default_nettype wire

// ===== src/cbf_checker.sv =====
// Port-level checker for the cassette block framer, bound to the top level.
// Depends on cbf_pkg for the payload types and tape constants.
`default_nettype none

module cbf_checker
  import cbf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        request_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire cbf_result_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Requests are never blocked while the result register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !request_stall)
    else $error("request stalled with empty result register");

  // A consumed payload byte always goes out on tape, and no tape byte means zero
  a_taken_emits: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.data_taken |-> result.tape_valid)
    else $error("payload byte taken without tape byte");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.tape_valid |-> result.tape_byte == ZERO_BYTE)
    else $error("tape byte nonzero without tape_valid");

  // Once the stream is done, only the end block's closing sync byte may appear
  a_done_tail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stream_done && result.tape_valid |->
      result.tape_byte == SYNC_BYTE && !result.data_taken)
    else $error("unexpected tape byte after end block");

endmodule

bind cassette_block_framer cbf_checker u_cbf_checker (
  .clk           (clk),
  .rst           (rst),
  .request_stall (request_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);

`default_nettype wire
